### design/drive_command_link_session_macros.svh
// ----------------------------------------------------------------------------
// Drive command link session assertion macros
// Shared property forms for the session checker.
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_LINK_SESSION_MACROS_SVH
`define DRIVE_COMMAND_LINK_SESSION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DCLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dcls_pkg.sv
// ----------------------------------------------------------------------------
// Drive command link session package
// Codes, limits and beat layouts shared by the session logic and its checker.
// ----------------------------------------------------------------------------
package dcls_pkg;

    localparam logic [1:0] MODE_DISARMED = 2'd0;
    localparam logic [1:0] MODE_ARMED    = 2'd1;
    localparam logic [1:0] MODE_ESTOP    = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CRC     = 3'd1;
    localparam logic [2:0] ERR_LEN     = 3'd2;
    localparam logic [2:0] ERR_SEQ     = 3'd3;
    localparam logic [2:0] ERR_STATE   = 3'd4;
    localparam logic [2:0] ERR_PAYLOAD = 3'd5;

    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_CRC   = 2'd1;
    localparam logic [1:0] FUNC_LEN   = 2'd2;
    localparam logic [1:0] FUNC_SEQ   = 2'd3;

    localparam logic [7:0] MSG_TWIST     = 8'd0;
    localparam logic [7:0] MSG_ARM       = 8'd1;
    localparam logic [7:0] MSG_DISARM    = 8'd2;
    localparam logic [7:0] MSG_ESTOP     = 8'd3;
    localparam logic [7:0] MSG_CLEAR     = 8'd4;
    localparam logic [7:0] MSG_HEARTBEAT = 8'd5;

    localparam logic [7:0]  SEQ_HALF    = 8'd127;
    localparam logic [7:0]  TWIST_LEN   = 8'd6;
    localparam int          REVERSE_BIT = 0;
    localparam logic [15:0] SAT16       = 16'hFFFF;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [7:0]         flag_byte;
        logic signed [15:0] twist_rate;
        logic signed [15:0] twist_speed;
        logic [7:0]         payload_len;
        logic [7:0]         msg_type;
        logic [7:0]         seq;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic [15:0]        len_drops;
        logic [15:0]        seq_drops;
        logic [15:0]        crc_drops;
        logic [15:0]        link_age;
        logic [15:0]        twist_age;
        logic               cmd_reverse;
        logic signed [15:0] cmd_rate;
        logic signed [15:0] cmd_speed;
        logic [7:0]         last_seq;
        logic [2:0]         fault_code;
        logic [1:0]         drive_mode;
    } out_beat_t;

endpackage

### design/drive_command_link_session.sv
// ----------------------------------------------------------------------------
// Drive command link session
// Sequence check, arm/disarm/estop state and twist capture with a status beat.
// ----------------------------------------------------------------------------
// Takes one frame or link-error beat per cycle while the output is not stalled
// and returns one status beat for each, in order. A beat lands in the input
// register, the session state and the status snapshot are worked out from it
// in one pass and written into the state registers and the result register
// together, so a status beat passes the input register and then the result
// register before output valid, and a new beat can be taken while the last is
// still in flight. The input side keeps taking beats while a status beat waits
// at the output, until the input register is also full.
module drive_command_link_session (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seq, msg_type, payload_len, twist_speed, twist_rate, flag_byte, now_ms
    input  logic [95:0]  s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drive_mode, fault_code, last_seq, cmd_speed, cmd_rate, cmd_reverse,
    // twist_age, link_age, crc_drops, seq_drops, len_drops, 2 zero bits
    output logic [127:0] m_axis_tdata
);

    function automatic logic [15:0] bump(input logic [15:0] c);
        return (c == dcls_pkg::SAT16) ? c : c + 16'd1;
    endfunction

    function automatic logic [15:0] age_of(input logic [31:0] now, input logic [31:0] then_ms);
        logic [31:0] d;
        d = now - then_ms;
        return (d[31:16] != 16'd0) ? dcls_pkg::SAT16 : d[15:0];
    endfunction

    logic               in_valid_reg;
    dcls_pkg::in_beat_t in_reg;
    logic [1:0]         in_func_reg;
    logic               out_valid_reg;
    dcls_pkg::out_beat_t out_reg;
    dcls_pkg::out_beat_t out_next;
    logic               adv;

    logic [1:0]  mode_reg,        mode_next;
    logic [2:0]  error_code_reg,  error_code_next;
    logic        seq_seen_reg,    seq_seen_next;
    logic [7:0]  prev_seq_reg,    prev_seq_next;
    logic [15:0] speed_cmd_reg,   speed_cmd_next;
    logic [15:0] rate_cmd_reg,    rate_cmd_next;
    logic        reverse_cmd_reg, reverse_cmd_next;
    logic        cmd_present_reg, cmd_present_next;
    logic [31:0] cmd_time_reg,    cmd_time_next;
    logic [31:0] link_time_reg,   link_time_next;
    logic [15:0] crc_count_reg,   crc_count_next;
    logic [15:0] seq_count_reg,   seq_count_next;
    logic [15:0] len_count_reg,   len_count_next;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        logic [7:0] step;
        step             = in_reg.seq - prev_seq_reg;
        mode_next        = mode_reg;
        error_code_next  = error_code_reg;
        seq_seen_next    = seq_seen_reg;
        prev_seq_next    = prev_seq_reg;
        speed_cmd_next   = speed_cmd_reg;
        rate_cmd_next    = rate_cmd_reg;
        reverse_cmd_next = reverse_cmd_reg;
        cmd_present_next = cmd_present_reg;
        cmd_time_next    = cmd_time_reg;
        link_time_next   = link_time_reg;
        crc_count_next   = crc_count_reg;
        seq_count_next   = seq_count_reg;
        len_count_next   = len_count_reg;

        unique case (in_func_reg)
            dcls_pkg::FUNC_FRAME:
            begin
                if (seq_seen_reg && (step == 8'd0 || step > dcls_pkg::SEQ_HALF))
                begin
                    seq_count_next  = bump(seq_count_reg);
                    error_code_next = dcls_pkg::ERR_SEQ;
                end
                else
                begin
                    seq_seen_next  = 1'b1;
                    prev_seq_next  = in_reg.seq;
                    link_time_next = in_reg.now_ms;
                    if (in_reg.msg_type == dcls_pkg::MSG_TWIST)
                    begin
                        if (mode_reg == dcls_pkg::MODE_ESTOP)
                        begin
                            error_code_next = dcls_pkg::ERR_STATE;
                        end
                        else if (in_reg.payload_len != dcls_pkg::TWIST_LEN)
                        begin
                            len_count_next  = bump(len_count_reg);
                            error_code_next = dcls_pkg::ERR_LEN;
                        end
                        else
                        begin
                            speed_cmd_next   = in_reg.twist_speed;
                            rate_cmd_next    = in_reg.twist_rate;
                            reverse_cmd_next = in_reg.flag_byte[dcls_pkg::REVERSE_BIT];
                            cmd_present_next = 1'b1;
                            cmd_time_next    = in_reg.now_ms;
                            error_code_next  = dcls_pkg::ERR_NONE;
                        end
                    end
                    else if (in_reg.msg_type > dcls_pkg::MSG_HEARTBEAT)
                    begin
                        error_code_next = dcls_pkg::ERR_PAYLOAD;
                    end
                    else if (in_reg.payload_len != 8'd0)
                    begin
                        len_count_next  = bump(len_count_reg);
                        error_code_next = dcls_pkg::ERR_LEN;
                    end
                    else
                    begin
                        error_code_next = dcls_pkg::ERR_NONE;
                        unique case (in_reg.msg_type)
                            dcls_pkg::MSG_ARM:
                            begin
                                if (mode_reg == dcls_pkg::MODE_DISARMED)
                                    mode_next = dcls_pkg::MODE_ARMED;
                                else
                                    error_code_next = dcls_pkg::ERR_STATE;
                            end
                            dcls_pkg::MSG_DISARM:
                            begin
                                mode_next = dcls_pkg::MODE_DISARMED;
                            end
                            dcls_pkg::MSG_ESTOP:
                            begin
                                mode_next = dcls_pkg::MODE_ESTOP;
                            end
                            dcls_pkg::MSG_CLEAR:
                            begin
                                if (mode_reg == dcls_pkg::MODE_ESTOP)
                                    mode_next = dcls_pkg::MODE_DISARMED;
                                else
                                    error_code_next = dcls_pkg::ERR_STATE;
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
            end
            dcls_pkg::FUNC_CRC:
            begin
                crc_count_next  = bump(crc_count_reg);
                error_code_next = dcls_pkg::ERR_CRC;
            end
            dcls_pkg::FUNC_LEN:
            begin
                len_count_next  = bump(len_count_reg);
                error_code_next = dcls_pkg::ERR_LEN;
            end
            default:
            begin
                seq_count_next  = bump(seq_count_reg);
                error_code_next = dcls_pkg::ERR_SEQ;
            end
        endcase

        out_next.pad           = 2'b00;
        out_next.drive_mode    = mode_next;
        out_next.fault_code    = error_code_next;
        out_next.last_seq      = prev_seq_next;
        out_next.cmd_speed     = speed_cmd_next;
        out_next.cmd_rate      = rate_cmd_next;
        out_next.cmd_reverse   = reverse_cmd_next;
        out_next.twist_age     = cmd_present_next ? age_of(in_reg.now_ms, cmd_time_next)
                                                  : dcls_pkg::SAT16;
        out_next.link_age      = seq_seen_next ? age_of(in_reg.now_ms, link_time_next)
                                               : dcls_pkg::SAT16;
        out_next.crc_drops     = crc_count_next;
        out_next.seq_drops     = seq_count_next;
        out_next.len_drops     = len_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= dcls_pkg::MODE_DISARMED;
            error_code_reg  <= dcls_pkg::ERR_NONE;
            seq_seen_reg    <= 1'b0;
            prev_seq_reg    <= 8'd0;
            speed_cmd_reg   <= 16'd0;
            rate_cmd_reg    <= 16'd0;
            reverse_cmd_reg <= 1'b0;
            cmd_present_reg <= 1'b0;
            cmd_time_reg    <= 32'd0;
            link_time_reg   <= 32'd0;
            crc_count_reg   <= 16'd0;
            seq_count_reg   <= 16'd0;
            len_count_reg   <= 16'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (adv)
            begin
                mode_reg        <= mode_next;
                error_code_reg  <= error_code_next;
                seq_seen_reg    <= seq_seen_next;
                prev_seq_reg    <= prev_seq_next;
                speed_cmd_reg   <= speed_cmd_next;
                rate_cmd_reg    <= rate_cmd_next;
                reverse_cmd_reg <= reverse_cmd_next;
                cmd_present_reg <= cmd_present_next;
                cmd_time_reg    <= cmd_time_next;
                link_time_reg   <= link_time_next;
                crc_count_reg   <= crc_count_next;
                seq_count_reg   <= seq_count_next;
                len_count_reg   <= len_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg      <= s_axis_tdata;
            in_func_reg <= s_axis_tuser;
        end
        if (adv)
            out_reg <= out_next;
    end

endmodule

### design/dcls_checker.sv
// ----------------------------------------------------------------------------
// Drive command link session checker
// Port-level checks on the status stream, bound to the session top level.
// ----------------------------------------------------------------------------
`include "drive_command_link_session_macros.svh"

module dcls_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [95:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    dcls_pkg::out_beat_t beat;
    logic                out_hs;
    logic [15:0]         prev_crc_reg;
    logic [15:0]         prev_seqd_reg;
    logic                in_hs;
    logic                stalled;
    logic                crc_beat;
    logic                crc_counted;
    logic                seq_beat;
    logic                seq_counted;

    assign beat   = m_axis_tdata;
    assign out_hs = m_axis_tvalid && m_axis_tready;
    assign in_hs  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == dcls_pkg::FUNC_CRC)
                    && (s_axis_tdata != 96'd0 || s_axis_tdata == 96'd0);

    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign crc_beat    = m_axis_tvalid && (beat.fault_code == dcls_pkg::ERR_CRC);
    assign crc_counted = (beat.crc_drops == dcls_pkg::SAT16) || (beat.crc_drops != prev_crc_reg)
                         || in_hs;
    assign seq_beat    = m_axis_tvalid && (beat.fault_code == dcls_pkg::ERR_SEQ);
    assign seq_counted = (beat.seq_drops == dcls_pkg::SAT16) || (beat.seq_drops != prev_seqd_reg)
                         || in_hs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_crc_reg  <= 16'd0;
            prev_seqd_reg <= 16'd0;
        end
        else if (out_hs)
        begin
            prev_crc_reg  <= beat.crc_drops;
            prev_seqd_reg <= beat.seq_drops;
        end
    end

    // hold a stalled status beat
    `DCLS_ASSERT_NEXT(a_valid_hold, stalled, m_axis_tvalid, "status beat dropped while stalled")
    `DCLS_ASSERT_NEXT(a_data_hold, stalled, $stable(m_axis_tdata), "status beat changed in stall")
    // crc drops only advance, and crc and sequence error beats bump their counts
    `DCLS_ASSERT_NOW(a_crc_mono, m_axis_tvalid, beat.crc_drops >= prev_crc_reg, "crc drops fell")
    `DCLS_ASSERT_NOW(a_crc_bump, crc_beat, crc_counted, "crc error without count")
    `DCLS_ASSERT_NOW(a_seq_bump, seq_beat, seq_counted, "sequence error without count")

endmodule

bind drive_command_link_session dcls_checker u_dcls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_drive_command_link_session.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command link session testbench
// Streams frames and link-error events into the session block. A predictor
// tracks the sequence check, arm/disarm/estop mode, stored twist, error code
// and drop counters, and expects one status beat per input beat. Each output
// beat is compared field by field. The run covers a short directed part,
// random traffic with random idling on both sides, a long output stall and a
// clock wrap.
// ----------------------------------------------------------------------------
module tb_drive_command_link_session;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 400;

    typedef struct packed {
        logic [1:0]         func;
        dcls_pkg::in_beat_t beat;
    } link_item_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    drive_command_link_session dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    link_item_t          outgoing_q[$];
    dcls_pkg::out_beat_t status_q[$];
    link_item_t          cur_item;

    int unsigned cycle_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    bit          quiet         = 1'b0;

    // predicted session state
    logic [1:0]  ctl_mode      = dcls_pkg::MODE_DISARMED;
    logic [2:0]  err_code      = dcls_pkg::ERR_NONE;
    logic        seq_valid     = 1'b0;
    logic [7:0]  accepted_seq  = '0;
    logic [15:0] speed_cmd     = '0;
    logic [15:0] rate_cmd      = '0;
    logic        reverse_cmd   = 1'b0;
    logic        twist_valid   = 1'b0;
    logic [31:0] twist_ms      = '0;
    logic [31:0] link_ms       = '0;
    logic [15:0] crc_cnt       = '0;
    logic [15:0] seq_cnt       = '0;
    logic [15:0] len_cnt       = '0;

    // generator view of the sequence stream
    logic [31:0] gen_now       = '0;
    logic [7:0]  gen_seq       = '0;
    logic        gen_seq_known = 1'b0;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == dcls_pkg::SAT16) ? dcls_pkg::SAT16 : c + 16'd1;
    endfunction

    function automatic logic [15:0] sat_age(input logic [31:0] now, input logic [31:0] then_ms);
        logic [31:0] d;
        d = now - then_ms;
        return (d > 32'(dcls_pkg::SAT16)) ? dcls_pkg::SAT16 : d[15:0];
    endfunction

    function automatic dcls_pkg::out_beat_t advance_session(input link_item_t it);
        dcls_pkg::out_beat_t st;
        dcls_pkg::in_beat_t  b;
        logic [7:0]          step;
        b = it.beat;
        st = '0;
        case (it.func)
            dcls_pkg::FUNC_FRAME:
            begin
                step = b.seq - accepted_seq;
                if (seq_valid && (step == 8'd0 || step > dcls_pkg::SEQ_HALF))
                begin
                    seq_cnt = sat_inc(seq_cnt);
                    err_code = dcls_pkg::ERR_SEQ;
                end
                else
                begin
                    seq_valid = 1'b1;
                    accepted_seq = b.seq;
                    link_ms = b.now_ms;
                    if (b.msg_type == dcls_pkg::MSG_TWIST)
                    begin
                        if (ctl_mode == dcls_pkg::MODE_ESTOP)
                            err_code = dcls_pkg::ERR_STATE;
                        else if (b.payload_len != dcls_pkg::TWIST_LEN)
                        begin
                            len_cnt = sat_inc(len_cnt);
                            err_code = dcls_pkg::ERR_LEN;
                        end
                        else
                        begin
                            speed_cmd = b.twist_speed;
                            rate_cmd = b.twist_rate;
                            reverse_cmd = b.flag_byte[dcls_pkg::REVERSE_BIT];
                            twist_valid = 1'b1;
                            twist_ms = b.now_ms;
                            err_code = dcls_pkg::ERR_NONE;
                        end
                    end
                    else if (b.msg_type > dcls_pkg::MSG_HEARTBEAT)
                        err_code = dcls_pkg::ERR_PAYLOAD;
                    else if (b.payload_len != 8'd0)
                    begin
                        len_cnt = sat_inc(len_cnt);
                        err_code = dcls_pkg::ERR_LEN;
                    end
                    else
                    begin
                        err_code = dcls_pkg::ERR_NONE;
                        case (b.msg_type)
                            dcls_pkg::MSG_ARM:
                                if (ctl_mode == dcls_pkg::MODE_DISARMED)
                                    ctl_mode = dcls_pkg::MODE_ARMED;
                                else
                                    err_code = dcls_pkg::ERR_STATE;
                            dcls_pkg::MSG_DISARM:
                                ctl_mode = dcls_pkg::MODE_DISARMED;
                            dcls_pkg::MSG_ESTOP:
                                ctl_mode = dcls_pkg::MODE_ESTOP;
                            dcls_pkg::MSG_CLEAR:
                                if (ctl_mode == dcls_pkg::MODE_ESTOP)
                                    ctl_mode = dcls_pkg::MODE_DISARMED;
                                else
                                    err_code = dcls_pkg::ERR_STATE;
                            default:
                                ;
                        endcase
                    end
                end
            end
            dcls_pkg::FUNC_CRC:
            begin
                crc_cnt = sat_inc(crc_cnt);
                err_code = dcls_pkg::ERR_CRC;
            end
            dcls_pkg::FUNC_LEN:
            begin
                len_cnt = sat_inc(len_cnt);
                err_code = dcls_pkg::ERR_LEN;
            end
            default:
            begin
                seq_cnt = sat_inc(seq_cnt);
                err_code = dcls_pkg::ERR_SEQ;
            end
        endcase
        st.drive_mode    = ctl_mode;
        st.fault_code    = err_code;
        st.last_seq      = accepted_seq;
        st.cmd_speed     = speed_cmd;
        st.cmd_rate      = rate_cmd;
        st.cmd_reverse   = reverse_cmd;
        st.twist_age     = twist_valid ? sat_age(b.now_ms, twist_ms) : dcls_pkg::SAT16;
        st.link_age      = seq_valid ? sat_age(b.now_ms, link_ms) : dcls_pkg::SAT16;
        st.crc_drops     = crc_cnt;
        st.seq_drops     = seq_cnt;
        st.len_drops     = len_cnt;
        return st;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("status beat %0d: %s expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endtask

    task automatic check_status(input dcls_pkg::out_beat_t got);
        dcls_pkg::out_beat_t want;
        results_seen++;
        if (status_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("status beat %0d arrived with nothing expected", results_seen);
            return;
        end
        want = status_q.pop_front();
        check_field("drive_mode", 32'(want.drive_mode), 32'(got.drive_mode));
        check_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
        check_field("last_seq", 32'(want.last_seq), 32'(got.last_seq));
        check_field("cmd_speed", 32'(want.cmd_speed), 32'(got.cmd_speed));
        check_field("cmd_rate", 32'(want.cmd_rate), 32'(got.cmd_rate));
        check_field("cmd_reverse", 32'(want.cmd_reverse), 32'(got.cmd_reverse));
        check_field("twist_age", 32'(want.twist_age), 32'(got.twist_age));
        check_field("link_age", 32'(want.link_age), 32'(got.link_age));
        check_field("crc_drops", 32'(want.crc_drops), 32'(got.crc_drops));
        check_field("seq_drops", 32'(want.seq_drops), 32'(got.seq_drops));
        check_field("len_drops", 32'(want.len_drops), 32'(got.len_drops));
    endtask

    function automatic int unsigned idle_chance();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 6;
            default: return 25;
        endcase
    endfunction

    task automatic push_frame(input logic [7:0] seq, input logic [7:0] msg,
                              input logic [7:0] len, input logic [15:0] speed,
                              input logic [15:0] rate, input logic [7:0] flags,
                              input logic [31:0] now);
        link_item_t it;
        logic [7:0] step;
        it.func             = dcls_pkg::FUNC_FRAME;
        it.beat.seq         = seq;
        it.beat.msg_type    = msg;
        it.beat.payload_len = len;
        it.beat.twist_speed = speed;
        it.beat.twist_rate  = rate;
        it.beat.flag_byte   = flags;
        it.beat.now_ms      = now;
        step = seq - gen_seq;
        if (!gen_seq_known || (step != 8'd0 && step <= dcls_pkg::SEQ_HALF))
        begin
            gen_seq_known = 1'b1;
            gen_seq = seq;
        end
        outgoing_q.push_back(it);
    endtask

    task automatic push_event(input logic [1:0] func, input logic [31:0] now);
        link_item_t it;
        it.func = func;
        it.beat = {$urandom, $urandom, $urandom};
        it.beat.now_ms = now;
        outgoing_q.push_back(it);
    endtask

    task automatic push_random(input int unsigned count);
        int unsigned roll;
        logic [7:0]  seq;
        logic [7:0]  msg;
        logic [7:0]  len;
        logic [1:0]  func;
        for (int unsigned i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                gen_now = gen_now + $urandom_range(0, 40);
            else if (roll < 85)
                gen_now = gen_now + $urandom_range(60000, 70000);
            else if (roll < 95)
                gen_now = gen_now + $urandom_range(0, 2000);
            else
                gen_now = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 9)
            begin
                case ($urandom_range(0, 2))
                    0:       func = dcls_pkg::FUNC_CRC;
                    1:       func = dcls_pkg::FUNC_LEN;
                    default: func = dcls_pkg::FUNC_SEQ;
                endcase
                push_event(func, gen_now);
                continue;
            end
            roll = $urandom_range(0, 99);
            if (!gen_seq_known)
                seq = 8'($urandom);
            else if (roll < 4)
                seq = gen_seq;
            else if (roll < 10)
                seq = gen_seq + 8'($urandom_range(128, 255));
            else if (roll < 15)
                seq = gen_seq + dcls_pkg::SEQ_HALF;
            else if (roll < 20)
                seq = gen_seq + 8'd1;
            else
                seq = gen_seq + 8'($urandom_range(1, 127));
            roll = $urandom_range(0, 99);
            if (roll < 32)
                msg = dcls_pkg::MSG_TWIST;
            else if (roll < 44)
                msg = dcls_pkg::MSG_ARM;
            else if (roll < 54)
                msg = dcls_pkg::MSG_DISARM;
            else if (roll < 62)
                msg = dcls_pkg::MSG_ESTOP;
            else if (roll < 72)
                msg = dcls_pkg::MSG_CLEAR;
            else if (roll < 88)
                msg = dcls_pkg::MSG_HEARTBEAT;
            else
                msg = 8'($urandom_range(6, 255));
            if (msg > dcls_pkg::MSG_HEARTBEAT || $urandom_range(0, 9) == 0)
                len = 8'($urandom);
            else
                len = (msg == dcls_pkg::MSG_TWIST) ? dcls_pkg::TWIST_LEN : 8'd0;
            push_frame(seq, msg, len, 16'($urandom), 16'($urandom), 8'($urandom), gen_now);
        end
    endtask

    task automatic wait_drained();
        while (outgoing_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
            @(posedge clk);
    endtask

    // sender
    int unsigned send_gap      = 0;
    int unsigned send_roll     = 0;
    int unsigned send_idle_pct = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (send_roll == 0)
            begin
                send_roll = $urandom_range(40, 200);
                send_idle_pct = idle_chance();
            end
            else
                send_roll--;
            if (s_axis_tvalid && s_axis_tready)
                status_q.push_back(advance_session(cur_item));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(0, 11);
                    s_axis_tvalid <= 1'b0;
                end
                else if (outgoing_q.size() != 0)
                begin
                    cur_item = outgoing_q.pop_front();
                    s_axis_tdata  <= cur_item.beat;
                    s_axis_tuser  <= cur_item.func;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    int unsigned hold_left      = 0;
    int unsigned recv_roll      = 0;
    int unsigned recv_idle_pct  = 0;
    bit          long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_status(dcls_pkg::out_beat_t'(m_axis_tdata));
            if (recv_roll == 0)
            begin
                recv_roll = $urandom_range(40, 200);
                recv_idle_pct = idle_chance();
            end
            else
                recv_roll--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 500)
            begin
                // back up the block while the sender keeps offering beats
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < recv_idle_pct)
            begin
                hold_left = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // error event before any frame: both ages saturated
        push_event(dcls_pkg::FUNC_CRC, 32'd0);
        // first frame accepted whatever its number, then step 0 and step 128
        push_frame(8'd255, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0, 32'd100);
        push_frame(8'd255, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0, 32'd110);
        push_frame(8'd127, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0, 32'd120);
        // step 127, extreme twist values
        push_frame(8'd126, dcls_pkg::MSG_TWIST, dcls_pkg::TWIST_LEN, 16'h8000, 16'h7FFF,
                   8'hFF, 32'd1000);
        // twist age just at and just past saturation
        push_frame(8'd127, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0, 32'd66535);
        push_frame(8'd128, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0, 32'd66536);
        push_frame(8'd129, dcls_pkg::MSG_ARM, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70000);
        push_frame(8'd130, dcls_pkg::MSG_ARM, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70001);
        push_frame(8'd131, dcls_pkg::MSG_TWIST, 8'd5, 16'h1234, 16'h5678, 8'h01, 32'd70002);
        push_frame(8'd132, dcls_pkg::MSG_TWIST, dcls_pkg::TWIST_LEN, 16'h7FFF, 16'h8000,
                   8'hFE, 32'd70003);
        // unknown types skip the length check
        push_frame(8'd133, 8'd255, 8'd7, 16'h0, 16'h0, 8'h0, 32'd70004);
        push_frame(8'd134, 8'd6, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70005);
        push_frame(8'd135, dcls_pkg::MSG_DISARM, 8'd1, 16'h0, 16'h0, 8'h0, 32'd70006);
        push_frame(8'd136, dcls_pkg::MSG_ESTOP, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70007);
        // twist under estop: state error even with a bad length
        push_frame(8'd137, dcls_pkg::MSG_TWIST, 8'd3, 16'h1111, 16'h2222, 8'h01, 32'd70008);
        push_frame(8'd138, dcls_pkg::MSG_ARM, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70009);
        push_frame(8'd139, dcls_pkg::MSG_CLEAR, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70010);
        push_frame(8'd140, dcls_pkg::MSG_CLEAR, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70011);
        push_frame(8'd141, dcls_pkg::MSG_DISARM, 8'd0, 16'h0, 16'h0, 8'h0, 32'd70012);
        push_event(dcls_pkg::FUNC_LEN, 32'd70013);
        push_event(dcls_pkg::FUNC_SEQ, 32'd70014);
        // ages across the clock wrap
        push_frame(8'd142, dcls_pkg::MSG_TWIST, dcls_pkg::TWIST_LEN, 16'h0001, 16'hFFFF,
                   8'h01, 32'hFFFF_FFF0);
        push_frame(8'd143, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0,
                   32'h0000_0010);
        push_frame(8'd0, dcls_pkg::MSG_HEARTBEAT, 8'd0, 16'h0, 16'h0, 8'h0,
                   32'h0000_0020);
        wait_drained();

        gen_now = $urandom;
        push_random(500);
        gen_now = 32'hFFFF_F000;
        push_random(550);
        // hold the sender until the block has returned everything
        wait_drained();

        quiet = 1'b1;
        push_random(190);
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && status_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
